// ===== src/bole_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bole_pkg;

  localparam int unsigned DefDepth    = 64;
  localparam int unsigned DefDataBits = 32;

  // command codes
  localparam logic [2:0] CMD_INSERT     = 3'd0;
  localparam logic [2:0] CMD_APPEND     = 3'd1;
  localparam logic [2:0] CMD_DELETE     = 3'd2;
  localparam logic [2:0] CMD_DELETE_END = 3'd3;
  localparam logic [2:0] CMD_SEARCH     = 3'd4;
  localparam logic [2:0] CMD_SIZE       = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_OOB   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_MISS  = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic find;
  } bole_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_search;
  } bole_stat_t;

endpackage
`default_nettype wire

// ===== src/bounded_ordered_list_engine_top.sv =====
// channel | signals                                    | direction
// input   | in_valid_i, in_ready_o, command_i, value_i,  | in
//         | position_i                                 |
// output  | out_valid_o, out_ready_i, status_o,         | out
//         | removed_value_o, found_index_o, entry_count_o |
// one command at a time: transfer, an execute state, then the result
// a search adds a find state for the first-match encode over the cells
// states per command: idle, execute, find (search only), then hold until taken
// reset clears the count and the controller; cell contents are not cleared
// a stalled result holds and blocks the input until taken
`timescale 1ns / 1ps
`default_nettype none
module bounded_ordered_list_engine_top
  import bole_pkg::*;
#(
  parameter int unsigned DEPTH     = DefDepth,
  parameter int unsigned DATA_BITS = DefDataBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic        [2:0]  command_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic        [7:0]  position_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [2:0]  status_o,
  output logic signed      [31:0] removed_value_o,
  output logic             [5:0]  found_index_o,
  output logic             [6:0]  entry_count_o
);

  bole_cmd_t  cmd;
  bole_stat_t stat;

  bole_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  bole_datapath #(
    .Depth    (DEPTH),
    .DataBits (DATA_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat),
    .command_i,
    .value_i,
    .position_i,
    .status_o,
    .removed_value_o,
    .found_index_o,
    .entry_count_o
  );

endmodule
`default_nettype wire

// ===== src/bole_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bole_ctrl
  import bole_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output bole_cmd_t       cmd_o,
  input  wire bole_stat_t stat_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0] state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: state_d = stat_i.is_search ? S_FIND : S_HOLD;
      S_FIND: state_d = S_HOLD;
      S_HOLD: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_HOLD);
  assign cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec  = (state_q == S_EXEC);
  assign cmd_o.find  = (state_q == S_FIND);

endmodule
`default_nettype wire

// ===== src/bole_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bole_datapath
  import bole_pkg::*;
#(
  parameter int unsigned Depth    = DefDepth,
  parameter int unsigned DataBits = DefDataBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bole_cmd_t          cmd_i,
  output bole_stat_t              stat_o,
  input  wire logic        [2:0]  command_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic        [7:0]  position_i,
  output logic             [2:0]  status_o,
  output logic signed      [31:0] removed_value_o,
  output logic             [5:0]  found_index_o,
  output logic             [6:0]  entry_count_o
);

  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned IW = $clog2(Depth);
  localparam int unsigned PW = (CW > 8) ? CW : 8;

  logic [DataBits-1:0] cells_q [Depth];
  logic [CW-1:0]       count_q, count_d;
  logic [2:0]          cmd_q;
  logic [DataBits-1:0] val_q;
  logic [7:0]          pos_q;
  logic [Depth-1:0]    match_q;
  logic [2:0]          status_q, status_d;
  logic [31:0]         removed_q, removed_d;
  logic [5:0]          found_q;

  logic [PW-1:0]       pos_w, cnt_w, tgt_w;
  logic                do_ins, do_del;
  logic [IW-1:0]       tgt;
  logic [DataBits-1:0] taken;
  logic [63:0]         taken_ext;

  // latch the command on transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      val_q <= DataBits'(64'(value_i));
      pos_q <= position_i;
    end
  end

  assign stat_o.is_search = (cmd_q == CMD_SEARCH);

  assign pos_w = PW'(pos_q);
  assign cnt_w = PW'(count_q);

  // decode: target index, status, shift enables
  always_comb begin
    status_d = ST_OK;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    tgt_w    = pos_w;
    count_d  = count_q;
    unique case (cmd_q)
      CMD_INSERT, CMD_APPEND: begin
        if (cmd_q == CMD_APPEND) tgt_w = cnt_w;
        if (tgt_w > cnt_w)                  status_d = ST_OOB;
        else if (cnt_w >= PW'(Depth))       status_d = ST_FULL;
        else begin
          do_ins  = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      CMD_DELETE, CMD_DELETE_END: begin
        if (cmd_q == CMD_DELETE_END) tgt_w = cnt_w - PW'(1);
        if (count_q == '0)                  status_d = ST_EMPTY;
        else if (tgt_w >= cnt_w)            status_d = ST_OOB;
        else begin
          do_del  = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      CMD_SEARCH: status_d = ST_MISS;
      default:    status_d = ST_OK;
    endcase
  end

  assign tgt       = tgt_w[IW-1:0];
  assign taken     = cells_q[tgt];
  assign taken_ext = 64'(signed'(taken));
  assign removed_d = do_del ? taken_ext[31:0] : 32'd0;

  // cell chain: shift up on insert, down on delete
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < Depth; i++) begin
        if (do_ins) begin
          if (IW'(i) == tgt)     cells_q[i] <= val_q;
          else if (IW'(i) > tgt) cells_q[i] <= cells_q[(i == 0) ? 0 : i - 1];
        end else if (do_del) begin
          if (IW'(i) >= tgt && i < Depth - 1) cells_q[i] <= cells_q[i + 1];
        end
      end
    end
  end

  // parallel key compare
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < Depth; i++) begin
        match_q[i] <= (cells_q[i] == val_q) && (CW'(i) < count_q);
      end
    end
  end

  // result and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      found_q   <= 6'd0;
    end else if (cmd_i.find) begin
      status_q <= ST_MISS;
      found_q  <= 6'd0;
      for (int i = Depth - 1; i >= 0; i--) begin
        if (match_q[i]) begin
          status_q <= ST_OK;
          found_q  <= 6'(i);
        end
      end
    end
  end

  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign found_index_o   = found_q;
  assign entry_count_o   = 7'(count_q);

endmodule
`default_nettype wire

// ===== src/bole_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bole_checker
  import bole_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic [6:0]  entry_count_o
);

  // one command in flight: no input while a result waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input open while result pending");

  // a transfer in is followed by a busy cycle
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("accepted twice");

  // status is a defined code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_MISS)) else $error("bad status");

  // count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(entry_count_o) <= DEPTH)) else $error("count overflow");

endmodule

bind bounded_ordered_list_engine_top bole_checker #(.DEPTH(DEPTH)) u_bole_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .status_o,
  .entry_count_o
);
`default_nettype wire

// ===== dv/list_result_checker.sv =====
`timescale 1ns / 1ps
module list_result_checker
  import bole_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic        [2:0]  command_i,
  input  logic signed [31:0] value_i,
  input  logic        [7:0]  position_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic        [2:0]  status_i,
  input  logic signed [31:0] removed_value_i,
  input  logic        [5:0]  found_index_i,
  input  logic        [6:0]  entry_count_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 result_count_o
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] removed;
    logic [5:0]  found;
    logic [6:0]  count;
  } list_result_t;

  localparam int unsigned ListDepth = DefDepth;

  logic [31:0]  list_model [ListDepth];
  int unsigned  list_len;
  list_result_t expected_results [$];

  assign pending_o = expected_results.size();

  // apply one command to the model list and return its result
  function automatic list_result_t apply_command(logic [2:0] cmd, logic [31:0] val,
                                                 logic [7:0] pos);
    list_result_t r;
    int unsigned p;
    r = '0;
    p = 32'(pos);
    if (cmd == CMD_APPEND) p = list_len;
    case (cmd)
      CMD_INSERT, CMD_APPEND: begin
        if (p > list_len) r.status = ST_OOB;
        else if (list_len >= ListDepth) r.status = ST_FULL;
        else begin
          for (int i = list_len; i > p; i--) list_model[i] = list_model[i-1];
          list_model[p] = val;
          list_len++;
        end
      end
      CMD_DELETE, CMD_DELETE_END: begin
        if (cmd == CMD_DELETE_END) p = list_len - 1;
        if (list_len == 0) r.status = ST_EMPTY;
        else if (p >= list_len) r.status = ST_OOB;
        else begin
          r.removed = list_model[p];
          for (int i = p; i < list_len - 1; i++) list_model[i] = list_model[i+1];
          list_len--;
        end
      end
      CMD_SEARCH: begin
        r.status = ST_MISS;
        for (int i = 0; i < list_len; i++) begin
          if (list_model[i] == val) begin
            r.status = ST_OK;
            r.found = 6'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    r.count = 7'(list_len);
    return r;
  endfunction

  // predict on input transfer, compare on output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_r;
    if (!rst_ni) begin
      list_len = 0;
      expected_results.delete();
      fail_count_o <= 0;
      result_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        expected_results.push_back(apply_command(command_i, value_i, position_i));
      if (out_valid_i && out_ready_i) begin
        result_count_o <= result_count_o + 1;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (status_i !== exp_r.status ||
              removed_value_i !== exp_r.removed ||
              found_index_i !== exp_r.found ||
              entry_count_i !== exp_r.count)
            fail_count_o <= fail_count_o + 1;
          if (status_i !== exp_r.status)
            $error("status expected %0d actual %0d", exp_r.status, status_i);
          if (removed_value_i !== exp_r.removed)
            $error("removed_value expected %0d actual %0d",
                   $signed(exp_r.removed), removed_value_i);
          if (found_index_i !== exp_r.found)
            $error("found_index expected %0d actual %0d", exp_r.found, found_index_i);
          if (entry_count_i !== exp_r.count)
            $error("entry_count expected %0d actual %0d", exp_r.count, entry_count_i);
        end
      end
    end
  end

endmodule

// ===== dv/bounded_ordered_list_engine_top_tb.sv =====
`timescale 1ns / 1ps
module bounded_ordered_list_engine_top_tb;
  import bole_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic        [2:0]  command_i = CMD_SIZE;
  logic signed [31:0] value_i = '0;
  logic        [7:0]  position_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic        [2:0]  status_o;
  logic signed [31:0] removed_value_o;
  logic        [5:0]  found_index_o;
  logic        [6:0]  entry_count_o;
  int                 fail_count, pending, result_count;
  int                 send_idle_pct, recv_idle_pct;
  int                 fill_len;
  logic signed [31:0] recent_vals [8];

  always #10 clk_i = ~clk_i;

  bounded_ordered_list_engine_top dut (.*);

  list_result_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .command_i, .value_i,
    .position_i, .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .removed_value_i(removed_value_o), .found_index_i(found_index_o),
    .entry_count_i(entry_count_o), .fail_count_o(fail_count), .pending_o(pending),
    .result_count_o(result_count)
  );

  // receiver stall pattern
  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  // one command transfer, with random sender gaps; valid stays high after
  // the transfer until the next gap, the next command or an explicit drop
  task automatic send_command(logic [2:0] cmd, logic signed [31:0] val, logic [7:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    value_i <= val;
    position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd inside {CMD_INSERT, CMD_APPEND}) recent_vals[$urandom_range(7)] = val;
  endtask

  // random command biased by list length, mostly legal
  task automatic random_command();
    int r;
    logic signed [31:0] v;
    logic [7:0] p;
    r = $urandom_range(99);
    v = ($urandom_range(3) == 0) ? recent_vals[$urandom_range(7)] : $urandom;
    if ($urandom_range(9) == 0) p = 8'($urandom);
    else p = 8'($urandom_range(fill_len + 1));
    if (r < 30) send_command(CMD_INSERT, v, p);
    else if (r < 45) send_command(CMD_APPEND, v, p);
    else if (r < 62) send_command(CMD_DELETE, v, p);
    else if (r < 72) send_command(CMD_DELETE_END, v, p);
    else if (r < 92) send_command(CMD_SEARCH, v, p);
    else if (r < 97) send_command(CMD_SIZE, v, p);
    else send_command(3'(6 + $urandom_range(1)), v, p);
  endtask

  // track length loosely for position bias
  always @(posedge clk_i) if (out_valid_o && out_ready_i) fill_len = entry_count_o;

  initial begin
    #50_000_000;
    $display("[bounded_ordered_list_engine_top] ERROR");
    $finish;
  end

  initial begin
    fill_len = 0;
    foreach (recent_vals[i]) recent_vals[i] = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list cases, extremes, every command
    send_command(CMD_DELETE, 0, 0);
    send_command(CMD_DELETE_END, 0, 0);
    send_command(CMD_SEARCH, 0, 0);
    send_command(CMD_INSERT, 5, 1);
    send_command(CMD_INSERT, 32'sh7fffffff, 0);
    send_command(CMD_APPEND, 32'sh80000000, 8'hff);
    send_command(CMD_INSERT, -1, 1);
    send_command(CMD_INSERT, 0, 3);
    send_command(CMD_INSERT, 9, 8'hff);
    send_command(CMD_SEARCH, -1, 0);
    send_command(CMD_SEARCH, 32'sh80000000, 0);
    send_command(CMD_SEARCH, 1234, 0);
    send_command(CMD_DELETE, 0, 4);
    send_command(CMD_DELETE, 0, 8'hff);
    send_command(CMD_DELETE, 0, 1);
    send_command(CMD_DELETE_END, 0, 0);
    send_command(CMD_SIZE, 0, 0);
    send_command(3'd6, -1, 8'hff);
    send_command(3'd7, 0, 0);
    // fill to capacity, then full cases
    for (int i = 0; i < DefDepth - 2; i++) send_command(CMD_APPEND, $urandom, 0);
    send_command(CMD_APPEND, 1, 0);
    send_command(CMD_INSERT, 1, 0);
    send_command(CMD_INSERT, 1, 65);
    send_command(CMD_SEARCH, 32'sh80000000, 0);
    send_command(CMD_DELETE, 0, 63);
    send_command(CMD_DELETE, 0, 0);
    in_valid_i <= 1'b0;

    // hold off until every result is back
    wait (pending == 0);
    @(posedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 71 : 0;
      recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 15 : 0;
      for (int n = 0; n < 610; n++) random_command();
    end
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    $display("covered %0d results over all commands, empty and full lists", result_count);
    if (fail_count == 0 && pending == 0) $display("[bounded_ordered_list_engine_top] OK");
    else $display("[bounded_ordered_list_engine_top] ERROR");
    $finish;
  end

endmodule
